// File: rtl/gbfp_pkg.sv
// ----------------------------------------------------------------------------
// gbfp_pkg
// Shared types and constants for the binary GNSS frame parser: sync bytes,
// parse phases, event codes and the result record.
// ----------------------------------------------------------------------------
package gbfp_pkg;

  localparam int unsigned MAX_PAYLOAD = 256;

  // Width of the payload byte counter, able to hold MAX_PAYLOAD itself
  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned MAXLEN_W = 9;
  localparam int unsigned LEN_W = 16;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = MAXLEN_W'(256);

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CHECK_A = 4'd7,
    PH_CHECK_B = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_GOOD    = 3'd2,
    EV_BADSUM  = 3'd3,
    EV_REJECT  = 3'd4
  } event_e;

  typedef struct packed {
    event_e           event_res;
    logic [7:0]       msg_class;
    logic [7:0]       msg_id;
    logic [LEN_W-1:0] msg_length;
    logic [7:0]       payload_index;
    logic [7:0]       payload_byte;
  } result_t;

endpackage

// File: rtl/gbfp_core_top.sv
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_core
// Byte-serial parser for binary GNSS frames with Fletcher-8 check.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and returns exactly one result beat for
// each. A byte is registered on entry, parsed by the frame state machine
// once the output register is free or draining, and its result is
// registered on the output. With the output taken every cycle one byte is
// accepted per cycle. The input register lets one more byte in while a
// result waits on a stalled output. max_length is written through the
// config channel, which is always ready, and must only be changed while
// no byte is in flight.
module gnss_binary_frame_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gbfp_pkg::MAXLEN_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          resync_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    event_res_o,
  output logic [7:0]                    msg_class_o,
  output logic [7:0]                    msg_id_o,
  output logic [gbfp_pkg::LEN_W-1:0]    msg_length_o,
  output logic [7:0]                    payload_index_o,
  output logic [7:0]                    payload_byte_o
);

  logic [gbfp_pkg::MAXLEN_W-1:0] max_length_q;
  logic                          st_valid;
  logic [7:0]                    st_byte;
  logic                          st_resync;
  logic                          fire;
  gbfp_pkg::result_t             res;
  gbfp_pkg::result_t             out_q;
  logic                          out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= gbfp_pkg::MAXLEN_RESET;
    end else if (cfg_valid_i) begin
      max_length_q <= cfg_data_i;
    end
  end

  // Advance when a byte is held and the output register is free or draining
  assign fire = st_valid && (!out_valid_q || out_ready_i);

  gbfp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .data_byte_i (data_byte_i),
    .resync_i    (resync_i),
    .take_i      (fire),
    .valid_o     (st_valid),
    .data_byte_o (st_byte),
    .resync_o    (st_resync)
  );

  gbfp_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (fire),
    .data_byte_i  (st_byte),
    .resync_i     (st_resync),
    .max_length_i (max_length_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = out_q.event_res;
  assign msg_class_o     = out_q.msg_class;
  assign msg_id_o        = out_q.msg_id;
  assign msg_length_o    = out_q.msg_length;
  assign payload_index_o = out_q.payload_index;
  assign payload_byte_o  = out_q.payload_byte;

endmodule

// File: rtl/gbfp_in_reg.sv
// ----------------------------------------------------------------------------
// gbfp_in_reg
// Input register: captures one received beat and holds it until the parse
// stage takes it.
// ----------------------------------------------------------------------------
module gbfp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       resync_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] data_byte_o,
  output logic       resync_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       resync_q;

  // Free when empty, or when the held beat leaves in this cycle
  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q   <= data_byte_i;
      resync_q <= resync_i;
    end
  end

  assign valid_o     = valid_q;
  assign data_byte_o = data_q;
  assign resync_o    = resync_q;

endmodule

// File: rtl/gbfp_step.sv
// ----------------------------------------------------------------------------
// gbfp_step
// Frame parse state machine: sync hunt, header capture, Fletcher-8 sums,
// payload streaming, length limit check and checksum verdict. One byte per step.
// ----------------------------------------------------------------------------
module gbfp_step (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           resync_i,
  input  logic [gbfp_pkg::MAXLEN_W-1:0]  max_length_i,
  output gbfp_pkg::result_t              res_o
);

  gbfp_pkg::phase_e                phase_q, phase_d;
  logic [7:0]                      sum_a_q, sum_a_d;
  logic [7:0]                      sum_b_q, sum_b_d;
  logic [7:0]                      class_q, class_d;
  logic [7:0]                      id_q, id_d;
  logic [gbfp_pkg::LEN_W-1:0]      length_q, length_d;
  logic [gbfp_pkg::CNT_W-1:0]      count_q, count_d;

  logic [7:0]                      sa_add, sb_add;
  logic [gbfp_pkg::LEN_W-1:0]      limit, new_len;
  logic [gbfp_pkg::CNT_W-1:0]      count_inc;
  gbfp_pkg::event_e                ev;
  logic [7:0]                      idx, pb;

  assign sa_add    = sum_a_q + data_byte_i;
  assign sb_add    = sum_b_q + sa_add;
  assign new_len   = {data_byte_i, length_q[7:0]};
  assign count_inc = count_q + gbfp_pkg::CNT_W'(1);

  // Effective limit is the smaller of the register and the hard ceiling
  assign limit = (gbfp_pkg::LEN_W'(max_length_i) > gbfp_pkg::LEN_W'(gbfp_pkg::MAX_PAYLOAD))
               ? gbfp_pkg::LEN_W'(gbfp_pkg::MAX_PAYLOAD)
               : gbfp_pkg::LEN_W'(max_length_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= gbfp_pkg::PH_SYNC1;
      sum_a_q  <= '0;
      sum_b_q  <= '0;
      class_q  <= '0;
      id_q     <= '0;
      length_q <= '0;
      count_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      sum_a_q  <= sum_a_d;
      sum_b_q  <= sum_b_d;
      class_q  <= class_d;
      id_q     <= id_d;
      length_q <= length_d;
      count_q  <= count_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    sum_a_d  = sum_a_q;
    sum_b_d  = sum_b_q;
    class_d  = class_q;
    id_d     = id_q;
    length_d = length_q;
    count_d  = count_q;
    ev       = gbfp_pkg::EV_NONE;
    idx      = '0;
    pb       = '0;
    if (resync_i) begin
      phase_d = gbfp_pkg::PH_SYNC1;
    end else begin
      unique case (phase_q)
        gbfp_pkg::PH_SYNC2: begin
          phase_d = (data_byte_i == gbfp_pkg::SYNC_SECOND) ? gbfp_pkg::PH_CLASS
                                                            : gbfp_pkg::PH_SYNC1;
        end
        gbfp_pkg::PH_CLASS: begin
          // Sums restart here: both take the class byte alone
          class_d = data_byte_i;
          sum_a_d = data_byte_i;
          sum_b_d = data_byte_i;
          phase_d = gbfp_pkg::PH_ID;
        end
        gbfp_pkg::PH_ID: begin
          id_d    = data_byte_i;
          sum_a_d = sa_add;
          sum_b_d = sb_add;
          phase_d = gbfp_pkg::PH_LEN_LO;
        end
        gbfp_pkg::PH_LEN_LO: begin
          length_d = gbfp_pkg::LEN_W'(data_byte_i);
          sum_a_d  = sa_add;
          sum_b_d  = sb_add;
          phase_d  = gbfp_pkg::PH_LEN_HI;
        end
        gbfp_pkg::PH_LEN_HI: begin
          length_d = new_len;
          sum_a_d  = sa_add;
          sum_b_d  = sb_add;
          if (new_len > limit) begin
            ev      = gbfp_pkg::EV_REJECT;
            phase_d = gbfp_pkg::PH_SYNC1;
          end else begin
            count_d = '0;
            phase_d = (new_len == '0) ? gbfp_pkg::PH_CHECK_A : gbfp_pkg::PH_PAYLOAD;
          end
        end
        gbfp_pkg::PH_PAYLOAD: begin
          sum_a_d = sa_add;
          sum_b_d = sb_add;
          ev      = gbfp_pkg::EV_PAYLOAD;
          idx     = count_q[7:0];
          pb      = data_byte_i;
          count_d = count_inc;
          if (gbfp_pkg::LEN_W'(count_inc) >= length_q) begin
            phase_d = gbfp_pkg::PH_CHECK_A;
          end
        end
        gbfp_pkg::PH_CHECK_A: begin
          if (data_byte_i == sum_a_q) begin
            phase_d = gbfp_pkg::PH_CHECK_B;
          end else begin
            ev      = gbfp_pkg::EV_BADSUM;
            phase_d = gbfp_pkg::PH_SYNC1;
          end
        end
        gbfp_pkg::PH_CHECK_B: begin
          ev      = (data_byte_i == sum_b_q) ? gbfp_pkg::EV_GOOD : gbfp_pkg::EV_BADSUM;
          phase_d = gbfp_pkg::PH_SYNC1;
        end
        default: begin
          // Hunt for the first sync byte; stray codes land here too
          phase_d = (data_byte_i == gbfp_pkg::SYNC_FIRST) ? gbfp_pkg::PH_SYNC2
                                                           : gbfp_pkg::PH_SYNC1;
        end
      endcase
    end
  end

  always_comb begin
    res_o.event_res     = ev;
    res_o.msg_class     = class_d;
    res_o.msg_id        = id_d;
    res_o.msg_length    = length_d;
    res_o.payload_index = idx;
    res_o.payload_byte  = pb;
  end

endmodule
